### sv/fisr_pkg.sv
package fisr_pkg;

   localparam logic [31:0] MAGIC_GUESS = 32'h5f3759df;
   localparam logic [31:0] FP_HALF = 32'h3f000000;
   localparam logic [31:0] FP_THREE_HALVES = 32'h3fc00000;
   localparam logic [31:0] FP_DEFAULT_NAN = 32'hffc00000;
   localparam logic [31:0] FP_QUIET_BIT = 32'h00400000;
   localparam int unsigned PIPE_DEPTH = 5;

   function automatic logic fp_is_nan(input logic [31:0] a);
      return (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
   endfunction

   function automatic logic fp_is_inf(input logic [31:0] a);
      return (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
   endfunction

   function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
      logic sgn;
      logic [7:0] ea;
      logic [7:0] eb;
      logic [23:0] ma;
      logic [23:0] mb;
      logic [47:0] p;
      logic [47:0] pn;
      logic [47:0] q;
      logic [5:0] lz;
      logic found;
      logic signed [11:0] e;
      logic [11:0] sh;
      logic [30:0] mag;
      logic g;
      logic st;
      logic [31:0] r;
      sgn = a[31] ^ b[31];
      ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      ma = {a[30:23] != 8'd0, a[22:0]};
      mb = {b[30:23] != 8'd0, b[22:0]};
      p = ma * mb;
      lz = 6'd0;
      found = 1'b0;
      for (int i = 47; i >= 0; i--) begin
         if (!found && p[i]) begin
            lz = 6'(47 - i);
            found = 1'b1;
         end
      end
      pn = p << lz;
      e = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126 - $signed({6'd0, lz});
      g = 1'b0;
      st = 1'b0;
      mag = 31'd0;
      if (e >= 12'sd255) begin
         mag = {8'hff, 23'd0};
      end else if (e >= 12'sd1) begin
         mag = {e[7:0], pn[46:24]};
         g = pn[23];
         st = |pn[22:0];
      end else begin
         sh = 12'(12'sd1 - e);
         if (sh > 12'd47) begin
            st = 1'b1;
         end else begin
            q = pn >> sh[5:0];
            mag = {8'd0, q[46:24]};
            g = q[23];
            st = (|q[22:0]) | ((pn << (6'd48 - sh[5:0])) != 48'd0);
         end
      end
      if (e < 12'sd255) begin
         mag = mag + 31'(g & (st | mag[0]));
      end
      if (fp_is_nan(a)) begin
         r = a | FP_QUIET_BIT;
      end else if (fp_is_nan(b)) begin
         r = b | FP_QUIET_BIT;
      end else if (fp_is_inf(a) || fp_is_inf(b)) begin
         if (a[30:0] == 31'd0 || b[30:0] == 31'd0) begin
            r = FP_DEFAULT_NAN;
         end else begin
            r = {sgn, 8'hff, 23'd0};
         end
      end else if (p == 48'd0) begin
         r = {sgn, 31'd0};
      end else begin
         r = {sgn, mag};
      end
      return r;
   endfunction

   function automatic logic [31:0] fp_sub(input logic [31:0] a, input logic [31:0] bin);
      logic [31:0] b;
      logic [31:0] x;
      logic [31:0] y;
      logic [7:0] ex;
      logic [7:0] ey;
      logic [7:0] d;
      logic [26:0] mx;
      logic [26:0] my;
      logic [26:0] ys;
      logic [27:0] s;
      logic [4:0] msb;
      logic signed [11:0] e;
      logic [11:0] ls;
      logic [30:0] mag;
      logic g;
      logic st;
      logic [31:0] r;
      b = {~bin[31], bin[30:0]};
      if (a[30:0] >= b[30:0]) begin
         x = a;
         y = b;
      end else begin
         x = b;
         y = a;
      end
      ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
      ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
      mx = {x[30:23] != 8'd0, x[22:0], 3'd0};
      my = {y[30:23] != 8'd0, y[22:0], 3'd0};
      d = ex - ey;
      if (d > 8'd26) begin
         ys = {26'd0, my != 27'd0};
      end else begin
         ys = my >> d[4:0];
         ys[0] = ys[0] | ((my << (5'd27 - d[4:0])) != 27'd0);
      end
      if (x[31] == y[31]) begin
         s = {1'b0, mx} + {1'b0, ys};
      end else begin
         s = {1'b0, mx} - {1'b0, ys};
      end
      msb = 5'd0;
      for (int i = 0; i < 28; i++) begin
         if (s[i]) begin
            msb = 5'(i);
         end
      end
      e = $signed({4'd0, ex}) + $signed({7'd0, msb}) - 12'sd26;
      if (msb == 5'd27) begin
         s = {1'b0, s[27:2], s[1] | s[0]};
      end else if (e < 12'sd1) begin
         ls = 12'({4'd0, ex} - 12'd1);
         s = s << ls[4:0];
         e = 12'sd0;
      end else begin
         s = s << (5'd26 - msb);
      end
      mag = {e[7:0], s[25:3]};
      g = s[2];
      st = s[1] | s[0];
      if (e >= 12'sd255) begin
         mag = {8'hff, 23'd0};
      end else begin
         mag = mag + 31'(g & (st | mag[0]));
      end
      if (fp_is_nan(a)) begin
         r = a | FP_QUIET_BIT;
      end else if (fp_is_nan(bin)) begin
         r = bin | FP_QUIET_BIT;
      end else if (fp_is_inf(x)) begin
         if (fp_is_inf(y) && x[31] != y[31]) begin
            r = FP_DEFAULT_NAN;
         end else begin
            r = x;
         end
      end else if (s == 28'd0) begin
         r = {x[31] & y[31], 31'd0};
      end else begin
         r = {x[31], mag};
      end
      return r;
   endfunction

endpackage

### sv/fisr_if.sv
interface fisr_req_if;
   import fisr_pkg::*;
   logic valid;
   logic ready;
   logic [31:0] value_bits;
   modport source (output valid, output value_bits, input ready);
   modport sink (input valid, input value_bits, output ready);
endinterface

interface fisr_rsp_if;
   import fisr_pkg::*;
   logic valid;
   logic ready;
   logic [31:0] result_bits;
   modport source (output valid, output result_bits, input ready);
   modport sink (input valid, input result_bits, output ready);
endinterface

### sv/fast_inverse_square_root.sv
// Throughput: one beat per cycle; five register stages, each holding one
// single-precision multiply or subtract, advance together unless the
// response is stalled.
// Reset clears the stage valid bits only; data registers are not reset.
module fast_inverse_square_root
   import fisr_pkg::*;
(
   input logic      clock,
   input logic      reset,
   fisr_req_if.sink   req_chan,
   fisr_rsp_if.source rsp_chan
);

   logic [PIPE_DEPTH-1:0] valid_ff;
   logic [PIPE_DEPTH-1:0] valid_in;
   logic advance;
   logic [31:0] guess_in;
   logic [31:0] half_ff;
   logic [31:0] est1_ff;
   logic [31:0] est2_ff;
   logic [31:0] est3_ff;
   logic [31:0] est4_ff;
   logic [31:0] p1_ff;
   logic [31:0] p2_ff;
   logic [31:0] diff_ff;
   logic [31:0] diff_in;
   logic [31:0] result_ff;

   assign advance = !valid_ff[PIPE_DEPTH-1] || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign valid_in = {valid_ff[PIPE_DEPTH-2:0], req_chan.valid};
   assign guess_in = MAGIC_GUESS - {req_chan.value_bits[31], req_chan.value_bits[31:1]};
   assign diff_in = fp_sub(FP_THREE_HALVES, p2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   fisr_fmul_stage u_half (
      .clock(clock), .enable(advance),
      .op_a(req_chan.value_bits), .op_b(FP_HALF), .product_ff(half_ff));

   fisr_fmul_stage u_p1 (
      .clock(clock), .enable(advance),
      .op_a(half_ff), .op_b(est1_ff), .product_ff(p1_ff));

   fisr_fmul_stage u_p2 (
      .clock(clock), .enable(advance),
      .op_a(p1_ff), .op_b(est2_ff), .product_ff(p2_ff));

   fisr_fmul_stage u_refine (
      .clock(clock), .enable(advance),
      .op_a(est4_ff), .op_b(diff_ff), .product_ff(result_ff));

   always_ff @(posedge clock) begin
      if (advance) begin
         est1_ff <= guess_in;
         est2_ff <= est1_ff;
         est3_ff <= est2_ff;
         est4_ff <= est3_ff;
         diff_ff <= diff_in;
      end
   end

   assign rsp_chan.valid = valid_ff[PIPE_DEPTH-1];
   assign rsp_chan.result_bits = result_ff;

endmodule

### sv/fisr_fmul_stage.sv
module fisr_fmul_stage
   import fisr_pkg::*;
(
   input  logic        clock,
   input  logic        enable,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic [31:0] product_ff
);

   logic [31:0] product_in;

   assign product_in = fp_mul(op_a, op_b);

   always_ff @(posedge clock) begin
      if (enable) begin
         product_ff <= product_in;
      end
   end

endmodule

### sv/fisr_checker.sv
module fisr_checker
   import fisr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_bits
);

   // A beat held back at the output keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bits))
      else $error("response beat changed while stalled");

   // The request side is only held off by a stalled response.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request refused without a stalled response");

   // Nothing emerges straight after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A request beat meets no back-pressure while the output is empty.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !rsp_valid |-> req_ready)
      else $error("request held off with an empty output");

endmodule

bind fast_inverse_square_root fisr_checker u_fisr_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_bits(rsp_chan.result_bits)
);
